// ===== rtl/rcas_pkg.sv =====
// shared types and constants of the radio channel access sequencer
package rcas_pkg;

  localparam int HB_BASE_MS   = 500;
  localparam int HB_JITTER_MS = 20;
  localparam int CTRL_MIN_LEN = 2;
  // 2^20 / HB_JITTER_MS rounded up, exact quotient for any 16-bit value
  localparam int HB_JITTER_RECIP = 52429;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_RECEIVE = 2'd2,
    OP_CARRIER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_AWAIT = 2'd0,
    MODE_TX    = 2'd1,
    MODE_OTHER = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE   = 2'd0,
    KIND_HEARTBEAT = 2'd1,
    KIND_DATA      = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_OWN_ID        = 3'd0,
    REG_BROADCAST_ID  = 3'd1,
    REG_CMD_START     = 3'd2,
    REG_CMD_END       = 3'd3,
    REG_CMD_HEARTBEAT = 3'd4,
    REG_BACKOFF_LIMIT = 3'd5,
    REG_OTHER_TIMEOUT = 3'd6,
    REG_QUEUE_DESTS   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_HB1, S_TICK, S_LEN, S_BYTES,
    S_CS0, S_CS1, S_CE0, S_CE1,
    S_HB_DIV, S_HB_WAIT, S_BO_DIV, S_BO_WAIT
  } state_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_START, EM_END, EM_OWN, EM_HB, EM_DATA, EM_BYTE
  } emit_t;

  typedef enum logic [2:0] {
    RX_NONE, RX_OTHER_START, RX_BACKOFF, RX_HB, RX_DATA, RX_OBD
  } rx_action_t;

  typedef struct packed {
    logic [7:0]  own_id;
    logic [7:0]  broadcast_id;
    logic [7:0]  cmd_start_burst;
    logic [7:0]  cmd_end_burst;
    logic [7:0]  cmd_heartbeat;
    logic [7:0]  backoff_limit;
    logic [15:0] other_burst_timeout;
    logic [63:0] queue_dest_ids;
  } cfg_t;

  typedef struct packed {
    logic  latch;
    logic  enq_exec;
    logic  hb_write0;
    logic  hb_write1;
    logic  set_mode_tx;
    logic  scan_take;
    logic  len_latch;
    logic  byte_read;
    emit_t emit;
    logic  emit_last;
    logic  div_start;
    logic  div_hb;
    logic  apply_bo;
    logic  apply_hb;
    logic  clear_sp;
    logic  set_other;
    logic  set_obd;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t        op;
    mode_t      mode;
    logic       hb_ok;
    logic       bo_expired;
    logic       obd_expired;
    logic       send_pending;
    logic       scan_found;
    logic       len_zero;
    logic       idx_last;
    logic       div_busy;
    rx_action_t rx_action;
  } ctrl_sts_t;

endpackage

// ===== rtl/rcas_ram.sv =====
// generic single write, single read ram with registered read
module rcas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rcas_div.sv =====
// iterative restoring remainder unit, one quotient bit a cycle
module rcas_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [7:0]  rem
);

  logic [15:0] dvd;
  logic [7:0]  dvs;
  logic [4:0]  cnt;
  logic [8:0]  trial;

  assign trial = {rem, dvd[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd16;
      rem  <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 8'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[7:0];
      end
      dvd <= {dvd[14:0], 1'b0};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rcas_ctrl.sv =====
// sequencing state machine of the channel access sequencer
module rcas_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rcas_pkg::ctrl_sts_t sts,
  output rcas_pkg::ctrl_cmd_t cmd
);
  import rcas_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: begin
        case (sts.op)
          OP_TICK:    state_next = sts.hb_ok ? S_HB1 : S_TICK;
          OP_RECEIVE: state_next = (sts.rx_action == RX_BACKOFF) ? S_BO_DIV : S_IDLE;
          OP_CARRIER: state_next = (sts.mode == MODE_AWAIT) ? S_BO_DIV : S_IDLE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_HB1: state_next = S_TICK;
      S_TICK: begin
        case (sts.mode)
          MODE_AWAIT: state_next = (sts.bo_expired && sts.send_pending) ? S_CS0 : S_IDLE;
          MODE_TX:    state_next = sts.scan_found ? S_LEN : S_CE0;
          MODE_OTHER: state_next = sts.obd_expired ? S_BO_DIV : S_IDLE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_LEN:     state_next = sts.len_zero ? S_IDLE : S_BYTES;
      S_BYTES:   if (sts.idx_last) state_next = S_IDLE;
      S_CS0:     state_next = S_CS1;
      S_CS1:     state_next = S_IDLE;
      S_CE0:     state_next = S_CE1;
      S_CE1:     state_next = S_HB_DIV;
      S_HB_DIV:  state_next = S_HB_WAIT;
      S_HB_WAIT: if (!sts.div_busy) state_next = S_BO_DIV;
      S_BO_DIV:  state_next = S_BO_WAIT;
      S_BO_WAIT: if (!sts.div_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.emit = EM_NONE;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.latch = start;
      S_EXEC: begin
        case (sts.op)
          OP_TICK:    cmd.hb_write0 = sts.hb_ok;
          OP_ENQUEUE: cmd.enq_exec = 1'b1;
          OP_RECEIVE: begin
            case (sts.rx_action)
              RX_OTHER_START: cmd.set_other = 1'b1;
              RX_OBD:         cmd.set_obd = 1'b1;
              RX_HB: begin
                cmd.emit      = EM_HB;
                cmd.emit_last = 1'b1;
              end
              RX_DATA: begin
                cmd.emit      = EM_DATA;
                cmd.emit_last = 1'b1;
              end
              default: ;
            endcase
          end
          default: cmd.set_obd = (sts.mode == MODE_OTHER);
        endcase
      end
      S_HB1: cmd.hb_write1 = 1'b1;
      S_TICK: begin
        if (sts.mode == MODE_AWAIT) begin
          cmd.set_mode_tx = sts.bo_expired && sts.send_pending;
        end else if (sts.mode == MODE_TX) begin
          cmd.scan_take = sts.scan_found;
        end
      end
      S_LEN: cmd.len_latch = 1'b1;
      S_BYTES: begin
        cmd.byte_read = 1'b1;
        cmd.emit      = EM_BYTE;
        cmd.emit_last = sts.idx_last;
      end
      S_CS0: cmd.emit = EM_START;
      S_CS1: begin
        cmd.emit      = EM_OWN;
        cmd.emit_last = 1'b1;
      end
      S_CE0: cmd.emit = EM_END;
      S_CE1: begin
        cmd.emit      = EM_OWN;
        cmd.emit_last = 1'b1;
        cmd.clear_sp  = 1'b1;
      end
      S_HB_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_hb    = 1'b1;
      end
      S_HB_WAIT: cmd.apply_hb = !sts.div_busy;
      S_BO_DIV:  cmd.div_start = 1'b1;
      S_BO_WAIT: cmd.apply_bo = !sts.div_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rcas_datapath.sv =====
// rings, deadlines, mode and result registers of the sequencer
module rcas_datapath #(
  parameter int NUM_QUEUES      = 4,
  parameter int SLOTS_PER_QUEUE = 8,
  parameter int MAX_PAYLOAD     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rcas_pkg::cfg_t      cfg,
  input  rcas_pkg::ctrl_cmd_t cmd,
  output rcas_pkg::ctrl_sts_t sts,
  input  logic [1:0]          op,
  input  logic [31:0]         now_ms,
  input  logic [31:0]         random_value,
  input  logic [2:0]          queue_index,
  input  logic [7:0]          data_byte,
  input  logic                byte_last,
  input  logic                rx_crc_ok,
  input  logic [7:0]          rx_dest_id,
  input  logic [7:0]          rx_sender_id,
  input  logic [7:0]          rx_first_byte,
  input  logic [6:0]          rx_length,
  input  logic                rx_ack_requested,
  output logic                result_strobe,
  output logic [1:0]          kind,
  output logic [7:0]          tx_dest_id,
  output logic [7:0]          tx_byte,
  output logic                needs_ack,
  output logic [7:0]          peer_id,
  output logic                last
);
  import rcas_pkg::*;

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW     = $clog2(SLOTS_PER_QUEUE);
  localparam int BW     = $clog2(MAX_PAYLOAD);
  localparam int CW     = $clog2(MAX_PAYLOAD + 1);
  localparam int BDEPTH = NUM_QUEUES * SLOTS_PER_QUEUE * MAX_PAYLOAD;
  localparam int LDEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int BAW    = $clog2(BDEPTH);
  localparam int LAW    = $clog2(LDEPTH);

  function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] s);
    return (s == SW'(SLOTS_PER_QUEUE - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [BAW-1:0] baddr(input logic [QW-1:0] q,
                                           input logic [SW-1:0] s,
                                           input logic [BW-1:0] i);
    return BAW'((int'(q) * SLOTS_PER_QUEUE + int'(s)) * MAX_PAYLOAD + int'(i));
  endfunction

  function automatic logic [LAW-1:0] laddr(input logic [QW-1:0] q,
                                           input logic [SW-1:0] s);
    return LAW'(int'(q) * SLOTS_PER_QUEUE + int'(s));
  endfunction

  // latched input beat
  op_t         op_r;
  logic [31:0] now_r, rnd_r;
  logic [2:0]  qi_r;
  logic [7:0]  byte_r, dest_r, sender_r, first_r;
  logic        blast_r, crc_r, ack_r;
  logic [6:0]  rxlen_r;

  mode_t       mode;
  logic [31:0] bod, obd, hbd;
  logic        sp;
  logic [SW-1:0] ws  [NUM_QUEUES];
  logic [SW-1:0] rs  [NUM_QUEUES];
  logic [CW-1:0] stg [NUM_QUEUES];

  logic [QW-1:0] sq;
  logic [SW-1:0] sslot;
  logic [7:0]    sel_dest;
  logic          sel_ack;
  logic [CW-1:0] len_r;
  logic [BW-1:0] idx;
  logic          from_ram;
  logic [7:0]    tx_byte_r;

  // ram ports
  logic           b_we, l_we;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [7:0]     b_wdata, b_rdata;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [CW-1:0]  l_wdata, l_rdata;

  logic          div_busy;
  logic [7:0]    div_rem;
  logic [7:0]    bo_lim;

  // heartbeat jitter by reciprocal multiply
  logic [31:0]   hb_prod;
  logic [11:0]   hb_quot;
  logic [15:0]   hb_diff;
  logic [4:0]    hb_jit;

  logic [QW-1:0] qx;
  logic          q_ok;
  logic [SW-1:0] enq_nx, hb_nx;
  logic [CW-1:0] cnt, cnt_new;
  logic          cnt_room, enq_commit;

  logic          found;
  logic [QW-1:0] fq;
  rx_action_t    rx_act;

  assign qx       = qi_r[QW-1:0];
  assign q_ok     = int'(qi_r) < NUM_QUEUES;
  assign enq_nx   = slot_after(ws[qx]);
  assign cnt      = stg[qx];
  assign cnt_room = cnt < CW'(MAX_PAYLOAD);
  assign cnt_new  = cnt_room ? cnt + CW'(1) : cnt;
  assign enq_commit = q_ok && blast_r && (cnt_new < CW'(MAX_PAYLOAD)) && (enq_nx != rs[qx]);
  assign hb_nx    = slot_after(ws[0]);
  assign bo_lim   = (cfg.backoff_limit == 8'd0) ? 8'd1 : cfg.backoff_limit;

  // high half mod the jitter span: quotient from the reciprocal, then subtract back
  assign hb_prod = 32'(rnd_r[31:16]) * 32'(HB_JITTER_RECIP);
  assign hb_quot = hb_prod[31:20];
  assign hb_diff = rnd_r[31:16] - (16'(hb_quot) * 16'(HB_JITTER_MS));

  // first non-empty ring in priority order
  always_comb begin
    found = 1'b0;
    fq    = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (!found && ws[q] != rs[q]) begin
        found = 1'b1;
        fq    = QW'(q);
      end
    end
  end

  always_comb begin
    rx_act = RX_NONE;
    if (mode != MODE_TX && crc_r) begin
      if (dest_r == cfg.broadcast_id) begin
        if (int'(rxlen_r) >= CTRL_MIN_LEN) begin
          if (first_r == cfg.cmd_start_burst) begin
            rx_act = RX_OTHER_START;
          end else if (first_r == cfg.cmd_end_burst) begin
            rx_act = RX_BACKOFF;
          end else if (first_r == cfg.cmd_heartbeat) begin
            rx_act = RX_HB;
          end
        end
      end else if (dest_r == cfg.own_id) begin
        rx_act = RX_DATA;
      end else begin
        rx_act = RX_OBD;
      end
    end
  end

  always_comb begin
    sts              = '0;
    sts.op           = op_r;
    sts.mode         = mode;
    sts.hb_ok        = !sp && (hbd < now_r) && (stg[0] == '0) && (hb_nx != rs[0]);
    sts.bo_expired   = bod < now_r;
    sts.obd_expired  = obd < now_r;
    sts.send_pending = sp;
    sts.scan_found   = found;
    sts.len_zero     = (l_rdata == '0);
    sts.idx_last     = (CW'(idx) + CW'(1)) == len_r;
    sts.div_busy     = div_busy;
    sts.rx_action    = rx_act;
  end

  // ram write port selection
  always_comb begin
    b_we    = 1'b0;
    b_waddr = baddr(qx, enq_nx, cnt[BW-1:0]);
    b_wdata = byte_r;
    l_we    = 1'b0;
    l_waddr = laddr(qx, enq_nx);
    l_wdata = cnt_new;
    if (cmd.enq_exec) begin
      b_we = q_ok && cnt_room;
      l_we = enq_commit;
    end else if (cmd.hb_write0) begin
      b_we    = 1'b1;
      b_waddr = baddr('0, hb_nx, '0);
      b_wdata = cfg.cmd_heartbeat;
      l_we    = 1'b1;
      l_waddr = laddr('0, hb_nx);
      l_wdata = CW'(2);
    end else if (cmd.hb_write1) begin
      b_we    = 1'b1;
      b_waddr = baddr('0, hb_nx, BW'(1));
      b_wdata = cfg.own_id;
    end
  end

  assign b_raddr = baddr(sq, sslot, idx);
  assign l_raddr = laddr(fq, slot_after(rs[fq]));

  rcas_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  rcas_ram #(.WIDTH(CW), .DEPTH(LDEPTH)) u_lens (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // backoff limit is a register, so it goes through the remainder unit
  rcas_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start && !cmd.div_hb),
    .dividend(rnd_r[15:0]),
    .divisor(bo_lim),
    .busy(div_busy), .rem(div_rem)
  );

  // input beat and scan payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(op);
      now_r    <= now_ms;
      rnd_r    <= random_value;
      qi_r     <= queue_index;
      byte_r   <= data_byte;
      blast_r  <= byte_last;
      crc_r    <= rx_crc_ok;
      dest_r   <= rx_dest_id;
      sender_r <= rx_sender_id;
      first_r  <= rx_first_byte;
      rxlen_r  <= rx_length;
      ack_r    <= rx_ack_requested;
    end
    if (cmd.div_start && cmd.div_hb) begin
      hb_jit <= hb_diff[4:0];
    end
    if (cmd.scan_take) begin
      sq       <= fq;
      sslot    <= slot_after(rs[fq]);
      sel_dest <= cfg.queue_dest_ids[8*int'(fq) +: 8];
      sel_ack  <= cfg.queue_dest_ids[8*int'(fq) +: 8] != cfg.broadcast_id;
    end
    if (cmd.len_latch) begin
      len_r <= l_rdata;
      idx   <= '0;
    end else if (cmd.byte_read) begin
      idx <= idx + BW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AWAIT;
      bod  <= '0;
      obd  <= '0;
      hbd  <= '0;
      sp   <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        ws[q]  <= '0;
        rs[q]  <= '0;
        stg[q] <= '0;
      end
    end else begin
      if (cmd.enq_exec && q_ok) begin
        stg[qx] <= blast_r ? '0 : cnt_new;
        if (enq_commit) begin
          ws[qx] <= enq_nx;
          sp     <= 1'b1;
        end
      end
      if (cmd.hb_write1) begin
        ws[0] <= hb_nx;
        sp    <= 1'b1;
      end
      if (cmd.set_mode_tx) mode <= MODE_TX;
      if (cmd.scan_take) rs[fq] <= slot_after(rs[fq]);
      if (cmd.clear_sp) sp <= 1'b0;
      if (cmd.set_other) begin
        mode <= MODE_OTHER;
        obd  <= now_r + 32'(cfg.other_burst_timeout);
      end
      if (cmd.set_obd) obd <= now_r + 32'(cfg.other_burst_timeout);
      if (cmd.apply_hb) hbd <= now_r + 32'(hb_jit) + 32'(HB_BASE_MS);
      if (cmd.apply_bo) begin
        bod  <= now_r + 32'(div_rem);
        mode <= MODE_AWAIT;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.emit != EM_NONE);
    end
    last      <= cmd.emit_last;
    from_ram  <= 1'b0;
    kind      <= KIND_TX_BYTE;
    tx_dest_id <= cfg.broadcast_id;
    tx_byte_r <= 8'd0;
    needs_ack <= 1'b0;
    peer_id   <= 8'd0;
    case (cmd.emit)
      EM_START: tx_byte_r <= cfg.cmd_start_burst;
      EM_END:   tx_byte_r <= cfg.cmd_end_burst;
      EM_OWN:   tx_byte_r <= cfg.own_id;
      EM_HB: begin
        kind       <= KIND_HEARTBEAT;
        tx_dest_id <= 8'd0;
        peer_id    <= sender_r;
      end
      EM_DATA: begin
        kind       <= KIND_DATA;
        tx_dest_id <= 8'd0;
        peer_id    <= sender_r;
        needs_ack  <= ack_r;
      end
      EM_BYTE: begin
        from_ram   <= 1'b1;
        tx_dest_id <= sel_dest;
        needs_ack  <= sel_ack;
      end
      default: ;
    endcase
  end

  assign tx_byte = from_ram ? b_rdata : tx_byte_r;

endmodule

// ===== rtl/radio_channel_access_sequencer.sv =====
// top level of the radio channel access sequencer: config registers, controller, datapath
// enqueue, receive and carrier: latched, then executed; receive and carrier may go on to draw a backoff
// tick: start or end of burst gives two beats; a message gives one beat a cycle once its length is read
// end of burst then takes the heartbeat jitter in one step and the backoff in the remainder unit
// throughput: one item at a time, busy high until the last step of the item is done
// reset: synchronous, rst high clears mode, deadlines, ring pointers and config to defaults
// result beats hold for one cycle only, the receiver cannot stall
module radio_channel_access_sequencer #(
  parameter int NUM_QUEUES      = 4,
  parameter int SLOTS_PER_QUEUE = 8,
  parameter int MAX_PAYLOAD     = 64
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] now_ms,
  input  logic [31:0] random_value,
  input  logic [2:0]  queue_index,
  input  logic [7:0]  data_byte,
  input  logic        byte_last,
  input  logic        rx_crc_ok,
  input  logic [7:0]  rx_dest_id,
  input  logic [7:0]  rx_sender_id,
  input  logic [7:0]  rx_first_byte,
  input  logic [6:0]  rx_length,
  input  logic        rx_ack_requested,
  // result beats
  output logic        result_strobe,
  output logic [1:0]  kind,
  output logic [7:0]  tx_dest_id,
  output logic [7:0]  tx_byte,
  output logic        needs_ack,
  output logic [7:0]  peer_id,
  output logic        last,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rcas_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // config writes are always taken; write only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id              <= 8'd1;
      cfg.broadcast_id        <= 8'd0;
      cfg.cmd_start_burst     <= 8'd1;
      cfg.cmd_end_burst       <= 8'd2;
      cfg.cmd_heartbeat       <= 8'd3;
      cfg.backoff_limit       <= 8'd15;
      cfg.other_burst_timeout <= 16'd300;
      cfg.queue_dest_ids      <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_OWN_ID:        cfg.own_id              <= cfg_data[7:0];
        REG_BROADCAST_ID:  cfg.broadcast_id        <= cfg_data[7:0];
        REG_CMD_START:     cfg.cmd_start_burst     <= cfg_data[7:0];
        REG_CMD_END:       cfg.cmd_end_burst       <= cfg_data[7:0];
        REG_CMD_HEARTBEAT: cfg.cmd_heartbeat       <= cfg_data[7:0];
        REG_BACKOFF_LIMIT: cfg.backoff_limit       <= cfg_data[7:0];
        REG_OTHER_TIMEOUT: cfg.other_burst_timeout <= cfg_data[15:0];
        REG_QUEUE_DESTS:   cfg.queue_dest_ids      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing of each item
  rcas_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // rings, deadlines, remainder unit and result register
  rcas_datapath #(
    .NUM_QUEUES(NUM_QUEUES),
    .SLOTS_PER_QUEUE(SLOTS_PER_QUEUE),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts),
    .op(op), .now_ms(now_ms), .random_value(random_value),
    .queue_index(queue_index), .data_byte(data_byte), .byte_last(byte_last),
    .rx_crc_ok(rx_crc_ok), .rx_dest_id(rx_dest_id), .rx_sender_id(rx_sender_id),
    .rx_first_byte(rx_first_byte), .rx_length(rx_length),
    .rx_ack_requested(rx_ack_requested),
    .result_strobe(result_strobe), .kind(kind), .tx_dest_id(tx_dest_id),
    .tx_byte(tx_byte), .needs_ack(needs_ack), .peer_id(peer_id), .last(last)
  );

endmodule
